// ----- hw/rtl/ttg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_pkg: shared types and constants of the triangle tangent generator
// Triangle record, result beat, back-end states, queue depths.
// ----------------------------------------------------------------------------
package ttg_pkg;

	localparam logic [1:0] VTX_LAST = 2'd2;

	localparam int TRI_QUEUE_DEPTH = 2;
	localparam int RES_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0][32:0] e1;
		logic [2:0][32:0] e2;
		logic [32:0]      du1;
		logic [32:0]      dv1;
		logic [32:0]      du2;
		logic [32:0]      dv2;
		logic [8:0][15:0] nrm;
	} tri_t;

	typedef struct packed {
		logic [15:0] tx;
		logic [15:0] ty;
		logic [15:0] tz;
		logic        deg;
		logic        last;
	} res_t;

	localparam int TRI_W = $bits(tri_t);
	localparam int RES_W = $bits(res_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_SIGN,
		S_SHR,
		S_SHL,
		S_VTX,
		S_DOT,
		S_PROJ,
		S_SQ,
		S_SQRT,
		S_DIV,
		S_EMIT
	} state_t;

endpackage

// ----- hw/rtl/ttg_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_fifo: small first-word-fall-through queue
// Register array with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module ttg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_MAX);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTR_MAX) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTR_MAX) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/ttg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_front: vertex intake
// Holds the first two vertices of a triangle; on the third it forms the edge
// and texture deltas and pushes one triangle record.
// ----------------------------------------------------------------------------
module ttg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	output logic               tri_push,
	output ttg_pkg::tri_t      tri_data,
	input  logic               tri_full
);
	import ttg_pkg::*;

	logic [1:0]             cnt_q;
	logic [1:0][2:0][31:0]  pos_q;
	logic [1:0][1:0][31:0]  tex_q;
	logic [1:0][2:0][15:0]  nrm_q;
	logic [2:0][31:0]       pos_in;
	logic                   accept;

	assign pos_in   = {pos_z, pos_y, pos_x};
	assign full     = (cnt_q == VTX_LAST) & tri_full;
	assign accept   = push & ~full;
	assign tri_push = accept & (cnt_q == VTX_LAST);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tri_data.e1[k] = {pos_q[1][k][31], pos_q[1][k]} - {pos_q[0][k][31], pos_q[0][k]};
			tri_data.e2[k] = {pos_in[k][31], pos_in[k]} - {pos_q[0][k][31], pos_q[0][k]};
		end
		tri_data.du1 = {tex_q[1][0][31], tex_q[1][0]} - {tex_q[0][0][31], tex_q[0][0]};
		tri_data.dv1 = {tex_q[1][1][31], tex_q[1][1]} - {tex_q[0][1][31], tex_q[0][1]};
		tri_data.du2 = {tex_u[31], tex_u} - {tex_q[0][0][31], tex_q[0][0]};
		tri_data.dv2 = {tex_v[31], tex_v} - {tex_q[0][1][31], tex_q[0][1]};
		tri_data.nrm = {norm_z, norm_y, norm_x,
		                nrm_q[1][2], nrm_q[1][1], nrm_q[1][0],
		                nrm_q[0][2], nrm_q[0][1], nrm_q[0][0]};
	end

	always_ff @(posedge clk) begin
		if (accept && cnt_q != VTX_LAST) begin
			pos_q[cnt_q[0]] <= pos_in;
			tex_q[cnt_q[0]] <= {tex_v, tex_u};
			nrm_q[cnt_q[0]] <= {norm_z, norm_y, norm_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= (cnt_q == VTX_LAST) ? '0 : cnt_q + 2'd1;
		end
	end

endmodule

// ----- hw/rtl/ttg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_back: tangent sequencer
// Shared multipliers, block scaler, bit-serial square root and divider;
// produces three tangent beats per triangle record.
// ----------------------------------------------------------------------------
module ttg_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ttg_pkg::tri_t tri_data,
	input  logic          tri_empty,
	output logic          tri_pop,
	output logic          res_push,
	output ttg_pkg::res_t res_data,
	input  logic          res_full
);
	import ttg_pkg::*;

	localparam int VW = 68;

	state_t state_q, state_d;

	tri_t                  tri_q;
	logic [4:0]            cnt_q;
	logic [1:0]            j_q, k_q;
	logic                  ph_q, deg_q, det_zero_q;
	logic signed [VW-1:0]  det_q;
	logic signed [VW-1:0]  w_q [3];
	logic signed [30:0]    t_q [3];
	logic signed [47:0]    dot_q;
	logic signed [67:0]    prod_a_s1;
	logic signed [63:0]    prod_b_s1;
	logic [63:0]           s_q, sqn_q, r_q, bit_q;
	logic [33:0]           rem_q;
	logic [14:0]           dsh_q, quo_q;
	logic [15:0]           tan_q [3];

	logic signed [33:0]    ma, mb;
	logic signed [47:0]    mc;
	logic signed [15:0]    md;
	logic [1:0]            comp, idx;
	logic [3:0]            nidx;
	logic [15:0]           nsel;
	logic                  all_fit, all_fit8, any_big, all_small, all_zero;
	logic signed [30:0]    uk;
	logic [30:0]           umag;
	logic [46:0]           dnum;
	logic [33:0]           r2, dv;
	logic                  ge;
	logic [14:0]           q_fin;
	logic [63:0]           rb;
	logic                  sq_ge;

	function automatic logic fits(input logic [VW-1:0] x);
		return (&x[VW-1:30]) | ~(|x[VW-1:30]);
	endfunction

	function automatic logic fits8(input logic [VW-1:0] x);
		return (&x[VW-1:38]) | ~(|x[VW-1:38]);
	endfunction

	function automatic logic big(input logic [VW-1:0] x);
		return (x[30] != x[29]) | (x[30] & x[29] & ~(|x[28:0]));
	endfunction

	function automatic logic smallv(input logic [VW-1:0] x);
		return (&x[30:20]) | ~(|x[30:20]);
	endfunction

	function automatic logic [32:0] pick3(input logic [2:0][32:0] v, input logic [1:0] i);
		case (i)
			2'd0:    return v[0];
			2'd1:    return v[1];
			2'd2:    return v[2];
			default: return '0;
		endcase
	endfunction

	assign comp = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
	assign idx  = cnt_q[1:0] - 2'd1;
	assign nidx = 4'(j_q) * 4'd3 + 4'(comp);
	assign nsel = tri_q.nrm[nidx];

	assign all_fit   = fits(w_q[0]) & fits(w_q[1]) & fits(w_q[2]);
	assign all_fit8  = fits8(w_q[0]) & fits8(w_q[1]) & fits8(w_q[2]);
	assign any_big   = big(w_q[0]) | big(w_q[1]) | big(w_q[2]);
	assign all_small = smallv(w_q[0]) & smallv(w_q[1]) & smallv(w_q[2]);
	assign all_zero  = (w_q[0] == '0) & (w_q[1] == '0) & (w_q[2] == '0);

	assign uk    = w_q[k_q][30:0];
	assign umag  = uk[30] ? 31'(-uk) : 31'(uk);
	assign dnum  = {1'b0, umag, 15'b0} + {15'b0, r_q[31:0]};
	assign r2    = {rem_q[32:0], dsh_q[14]};
	assign dv    = {1'b0, r_q[31:0], 1'b0};
	assign ge    = (r2 >= dv);
	assign q_fin = {quo_q[13:0], ge};
	assign rb    = r_q + bit_q;
	assign sq_ge = (sqn_q >= rb);

	always_comb begin
		ma = '0;
		mb = '0;
		mc = '0;
		md = '0;
		case (state_q)
			S_MUL: begin
				mb = cnt_q[0] ? {tri_q.dv1[32], tri_q.dv1} : {tri_q.dv2[32], tri_q.dv2};
				if (cnt_q[3:1] == 3'd0) begin
					ma = cnt_q[0] ? {tri_q.du2[32], tri_q.du2} : {tri_q.du1[32], tri_q.du1};
				end else begin
					ma = cnt_q[0] ? 34'(signed'(pick3(tri_q.e2, cnt_q[2:1] - 2'd1)))
					              : 34'(signed'(pick3(tri_q.e1, cnt_q[2:1] - 2'd1)));
				end
			end
			S_DOT: begin
				ma = 34'(t_q[comp]);
				mb = 34'(signed'(nsel));
			end
			S_SQ: begin
				ma = 34'(signed'(w_q[comp][30:0]));
				mb = 34'(signed'(w_q[comp][30:0]));
			end
			S_PROJ: begin
				mc = dot_q;
				md = signed'(nsel);
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (!tri_empty) state_d = S_MUL;
			S_MUL:  if (cnt_q == 5'd8) state_d = S_SIGN;
			S_SIGN: state_d = S_SHR;
			S_SHR: begin
				if (all_fit) begin
					if (all_zero) state_d = ph_q ? S_EMIT : S_VTX;
					else          state_d = S_SHL;
				end
			end
			S_SHL:  if (any_big) state_d = ph_q ? S_SQ : S_VTX;
			S_VTX:  state_d = det_zero_q ? S_EMIT : S_DOT;
			S_DOT:  if (cnt_q == 5'd3) state_d = S_PROJ;
			S_PROJ: if (cnt_q == 5'd3) state_d = S_SHR;
			S_SQ:   if (cnt_q == 5'd3) state_d = S_SQRT;
			S_SQRT: if (cnt_q == 5'd31) state_d = S_DIV;
			S_DIV:  if (cnt_q == 5'd15 && k_q == 2'd2) state_d = S_EMIT;
			S_EMIT: if (!res_full) state_d = (j_q == VTX_LAST) ? S_IDLE : S_VTX;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		tri_pop       = (state_q == S_IDLE) & ~tri_empty;
		res_push      = (state_q == S_EMIT) & ~res_full;
		res_data.tx   = deg_q ? '0 : tan_q[0];
		res_data.ty   = deg_q ? '0 : tan_q[1];
		res_data.tz   = deg_q ? '0 : tan_q[2];
		res_data.deg  = deg_q;
		res_data.last = (j_q == VTX_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			j_q        <= '0;
			k_q        <= '0;
			ph_q       <= 1'b0;
			deg_q      <= 1'b0;
			det_zero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q || (state_q == S_DIV && cnt_q == 5'd15)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 5'd1;
			end
			case (state_q)
				S_IDLE: begin
					ph_q <= 1'b0;
					j_q  <= '0;
				end
				S_SIGN: det_zero_q <= (det_q == '0);
				S_SHR:  if (all_fit && all_zero && ph_q) deg_q <= 1'b1;
				S_VTX: begin
					deg_q <= det_zero_q;
					k_q   <= '0;
				end
				S_PROJ: ph_q <= 1'b1;
				S_DIV: begin
					if (cnt_q == 5'd15) begin
						k_q <= k_q + 2'd1;
					end
				end
				S_EMIT: if (!res_full) j_q <= j_q + 2'd1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_a_s1 <= ma * mb;
		prod_b_s1 <= mc * md;
		case (state_q)
			S_IDLE: if (!tri_empty) tri_q <= tri_data;
			S_MUL: begin
				if (cnt_q != 5'd0) begin
					if (cnt_q[3:1] == 3'd0 || cnt_q == 5'd2) begin
						if (cnt_q == 5'd1) det_q <= prod_a_s1;
						else               det_q <= det_q - prod_a_s1;
					end else begin
						if (cnt_q[0]) w_q[cnt_q[2:1] - 2'd1] <= prod_a_s1;
						else          w_q[cnt_q[2:1] - 2'd2] <= w_q[cnt_q[2:1] - 2'd2] - prod_a_s1;
					end
				end
			end
			S_SIGN: begin
				if (det_q < 0) begin
					for (int k = 0; k < 3; k++) w_q[k] <= -w_q[k];
				end
			end
			S_SHR: begin
				if (!all_fit) begin
					for (int k = 0; k < 3; k++) w_q[k] <= all_fit8 ? w_q[k] >>> 1 : w_q[k] >>> 8;
				end else if (all_zero && !ph_q) begin
					for (int k = 0; k < 3; k++) t_q[k] <= '0;
				end
			end
			S_SHL: begin
				if (any_big) begin
					if (!ph_q) begin
						for (int k = 0; k < 3; k++) t_q[k] <= w_q[k][30:0];
					end
				end else begin
					for (int k = 0; k < 3; k++) w_q[k] <= all_small ? w_q[k] <<< 8 : w_q[k] <<< 1;
				end
			end
			S_DOT: begin
				if (cnt_q == 5'd1)      dot_q <= prod_a_s1[47:0];
				else if (cnt_q != 5'd0) dot_q <= dot_q + prod_a_s1[47:0];
			end
			S_PROJ: begin
				if (cnt_q != 5'd0) begin
					w_q[idx] <= (VW'(t_q[idx]) <<< 28) - VW'(prod_b_s1);
				end
			end
			S_SQ: begin
				if (cnt_q == 5'd1) s_q <= prod_a_s1[63:0];
				else if (cnt_q == 5'd2) s_q <= s_q + prod_a_s1[63:0];
				else if (cnt_q == 5'd3) begin
					sqn_q <= s_q + prod_a_s1[63:0];
					r_q   <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			S_SQRT: begin
				if (sq_ge) begin
					sqn_q <= sqn_q - rb;
					r_q   <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV: begin
				if (cnt_q == 5'd0) begin
					rem_q <= 34'(dnum[46:15]);
					dsh_q <= dnum[14:0];
					quo_q <= '0;
				end else begin
					rem_q <= ge ? r2 - dv : r2;
					quo_q <= q_fin;
					dsh_q <= {dsh_q[13:0], 1'b0};
					if (cnt_q == 5'd15) begin
						tan_q[k_q] <= uk[30] ? -{1'b0, q_fin} : {1'b0, q_fin};
					end
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result beat pushed into full queue");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_data.deg |-> res_data.tx == '0 && res_data.ty == '0 && res_data.tz == '0)
		else $error("degenerate beat with non-zero tangent");
	a_tan_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res_data.deg |->
		($signed(res_data.tx) <= 16384 && $signed(res_data.tx) >= -16384 &&
		 $signed(res_data.ty) <= 16384 && $signed(res_data.ty) >= -16384 &&
		 $signed(res_data.tz) <= 16384 && $signed(res_data.tz) >= -16384))
		else $error("tangent component out of range");
	a_len_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> r_q[63:29] != '0) else $error("length below scaled bound");
`endif

endmodule

// ----- hw/rtl/triangle_tangent_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_generator: per-triangle tangent with Gram-Schmidt step
// Vertices go in as beats on a push/full channel; each third vertex closes a
// triangle, which yields three tangent beats (last set on the third) on an
// empty/pop channel, oldest first.
// A triangle record is formed in the cycle the third vertex is taken.
// The back sequencer works one triangle at a time: two shared multipliers,
// a block scaler, a 32-step square root and a 15-step divider serve all
// nine tangent components. A triangle with a zero determinant skips the
// square root and the divider.
// The front keeps taking vertices while the back works, until the triangle
// queue is full; full then rises on a third vertex only.
// A stalled receiver fills the result queue and holds the back sequencer;
// no beat is lost. Reset clears the vertex count and both queues.
// ----------------------------------------------------------------------------
module triangle_tangent_generator #(
	parameter int TRI_DEPTH = ttg_pkg::TRI_QUEUE_DEPTH,
	parameter int RES_DEPTH = ttg_pkg::RES_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_y,
	output logic signed [15:0] tangent_z,
	output logic               degenerate,
	output logic               last
);
	import ttg_pkg::*;

	tri_t tri_in, tri_out;
	res_t res_in, res_out;
	logic tri_push, tri_full, tri_empty, tri_pop;
	logic res_push, res_full;

	ttg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.tex_u    (tex_u),
		.tex_v    (tex_v),
		.norm_x   (norm_x),
		.norm_y   (norm_y),
		.norm_z   (norm_z),
		.tri_push (tri_push),
		.tri_data (tri_in),
		.tri_full (tri_full)
	);

	ttg_fifo #(.WIDTH(TRI_W), .DEPTH(TRI_DEPTH)) u_tri_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tri_push),
		.wr_data (tri_in),
		.full    (tri_full),
		.rd_en   (tri_pop),
		.rd_data (tri_out),
		.empty   (tri_empty)
	);

	ttg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_data  (tri_out),
		.tri_empty (tri_empty),
		.tri_pop   (tri_pop),
		.res_push  (res_push),
		.res_data  (res_in),
		.res_full  (res_full)
	);

	ttg_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign tangent_x  = res_out.tx;
	assign tangent_y  = res_out.ty;
	assign tangent_z  = res_out.tz;
	assign degenerate = res_out.deg;
	assign last       = res_out.last;

endmodule

// ----- tb/sv/triangle_tangent_generator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_generator_test: self-checking bench for the tangent block
// Vertices are pushed three to a triangle. Each closed triangle is predicted
// in 128-bit integer arithmetic: block scaling, Gram-Schmidt against each
// normal, integer square root and rounded divide. The three tangent beats
// are checked field by field as they are popped. Directed corners, random
// triangles under changing idle rates and a long receiver stall are run.
// ----------------------------------------------------------------------------
module triangle_tangent_generator_test;
	import ttg_pkg::*;

	typedef logic signed [127:0] wide_t;
	localparam wide_t W30 = 128'sd1 <<< 30;
	localparam longint L29 = 64'sd1 <<< 29;
	localparam longint CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
	logic signed [15:0] norm_x = '0, norm_y = '0, norm_z = '0;
	logic full, empty, degenerate, last;
	logic signed [15:0] tangent_x, tangent_y, tangent_z;

	res_t tangent_queue[$];
	int errors = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	int rx_hold = 0;
	longint cycles = 0;

	int vtx_pos[3][3];
	int vtx_tex[3][2];
	shortint vtx_nrm[3][3];
	int vtx_slot = 0;

	triangle_tangent_generator i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.empty(empty), .pop(pop), .tangent_x(tangent_x), .tangent_y(tangent_y),
		.tangent_z(tangent_z), .degenerate(degenerate), .last(last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("triangle_tangent_generator_test: errors");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// results beats popped and compared against the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (pop && !empty) begin
			if (tangent_queue.size() == 0) begin
				report("tangent beat with nothing predicted");
			end else begin
				want = tangent_queue.pop_front();
				if (tangent_x !== want.tx || tangent_y !== want.ty || tangent_z !== want.tz)
					report($sformatf("tangent %0d %0d %0d, want %0d %0d %0d",
						tangent_x, tangent_y, tangent_z, $signed(want.tx),
						$signed(want.ty), $signed(want.tz)));
				if (degenerate !== want.deg)
					report($sformatf("degenerate %b, want %b", degenerate, want.deg));
				if (last !== want.last)
					report($sformatf("last %b, want %b", last, want.last));
			end
		end
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle);
		end
	end

	function automatic bit block_scale(input wide_t vi[3], output longint vo[3]);
		wide_t v[3];
		longint mx;
		bit fits;
		v = vi;
		forever begin
			fits = 1'b1;
			for (int k = 0; k < 3; k++)
				if (v[k] >= W30 || v[k] < -W30) fits = 1'b0;
			if (fits) break;
			for (int k = 0; k < 3; k++) v[k] = v[k] >>> 1;
		end
		for (int k = 0; k < 3; k++) vo[k] = longint'(v[k]);
		if (vo[0] == 0 && vo[1] == 0 && vo[2] == 0) return 1'b0;
		forever begin
			mx = 0;
			for (int k = 0; k < 3; k++) begin
				if (vo[k] > mx) mx = vo[k];
				if (-vo[k] > mx) mx = -vo[k];
			end
			if (mx >= L29) break;
			for (int k = 0; k < 3; k++) vo[k] = vo[k] * 2;
		end
		return 1'b1;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// three tangent beats of the triangle held in the vertex slots
	task automatic predict_triangle();
		longint e1[3], e2[3], du1, dv1, du2, dv2, t[3], u[3], n[3], dot;
		wide_t det, raw[3], tp[3];
		longint unsigned s, len, num, q;
		bit ok;
		res_t beat;
		for (int k = 0; k < 3; k++) begin
			e1[k] = longint'(vtx_pos[1][k]) - longint'(vtx_pos[0][k]);
			e2[k] = longint'(vtx_pos[2][k]) - longint'(vtx_pos[0][k]);
		end
		du1 = longint'(vtx_tex[1][0]) - longint'(vtx_tex[0][0]);
		dv1 = longint'(vtx_tex[1][1]) - longint'(vtx_tex[0][1]);
		du2 = longint'(vtx_tex[2][0]) - longint'(vtx_tex[0][0]);
		dv2 = longint'(vtx_tex[2][1]) - longint'(vtx_tex[0][1]);
		det = wide_t'(du1) * wide_t'(dv2) - wide_t'(du2) * wide_t'(dv1);
		for (int k = 0; k < 3; k++) begin
			raw[k] = wide_t'(e1[k]) * wide_t'(dv2) - wide_t'(e2[k]) * wide_t'(dv1);
			if (det < 0) raw[k] = -raw[k];
		end
		if (!block_scale(raw, t))
			for (int k = 0; k < 3; k++) t[k] = 0;
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) n[k] = vtx_nrm[j][k];
			dot = t[0] * n[0] + t[1] * n[1] + t[2] * n[2];
			for (int k = 0; k < 3; k++)
				tp[k] = wide_t'(t[k] * (64'sd1 <<< 28) - dot * n[k]);
			ok = (det != 0);
			if (ok) ok = block_scale(tp, u);
			beat = '0;
			if (ok) begin
				s = 0;
				for (int k = 0; k < 3; k++) s = s + longint'(u[k] * u[k]);
				len = int_sqrt(s);
				for (int k = 0; k < 3; k++) begin
					num = (u[k] < 0 ? -u[k] : u[k]) << 14;
					q = (2 * num + len) / (2 * len);
					if (u[k] < 0) q = -q;
					if (k == 0) beat.tx = q[15:0];
					if (k == 1) beat.ty = q[15:0];
					if (k == 2) beat.tz = q[15:0];
				end
			end else begin
				beat.deg = 1'b1;
			end
			beat.last = (j == 2);
			tangent_queue.push_back(beat);
		end
	endtask

	task automatic send_vertex(input int px, py, pz, tu, tv, input shortint nx, ny, nz);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		pos_x <= px; pos_y <= py; pos_z <= pz; tex_u <= tu; tex_v <= tv;
		norm_x <= nx; norm_y <= ny; norm_z <= nz;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		vtx_pos[vtx_slot] = '{px, py, pz};
		vtx_tex[vtx_slot] = '{tu, tv};
		vtx_nrm[vtx_slot] = '{nx, ny, nz};
		if (vtx_slot == 2) begin
			vtx_slot = 0;
			predict_triangle();
		end else begin
			vtx_slot++;
		end
	endtask

	function automatic int rand_coord(input int mode);
		if (mode == 0) return $urandom;
		if (mode == 1) return int'($urandom_range(2000000)) - 1000000;
		return int'($urandom_range(600)) - 300;
	endfunction

	function automatic shortint rand_norm(input bit wild);
		if (wild) return shortint'($urandom);
		return shortint'(int'($urandom_range(32768)) - 16384);
	endfunction

	// well-formed triangles mostly; some with shared texcoords or collinear edges
	task automatic send_random_triangle();
		int mode, kind, tu0, tv0;
		bit wild;
		mode = $urandom_range(2);
		kind = $urandom_range(9);
		wild = ($urandom_range(4) == 0);
		tu0 = rand_coord(mode);
		tv0 = rand_coord(mode);
		for (int j = 0; j < 3; j++) begin
			if (kind == 0)
				send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), tu0, tv0,
					rand_norm(wild), rand_norm(wild), rand_norm(wild));
			else if (kind == 1)
				send_vertex(j * 5, j * 5, j * 5, rand_coord(mode), rand_coord(mode),
					rand_norm(wild), rand_norm(wild), rand_norm(wild));
			else
				send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
					rand_coord(mode), rand_coord(mode),
					rand_norm(wild), rand_norm(wild), rand_norm(wild));
		end
	endtask

	task automatic drain();
		while (tangent_queue.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic test_directed();
		const int MX = 32'h7fffffff;
		const int MN = 32'h80000000;
		// plain right-angle triangle
		send_vertex(0, 0, 0, 0, 0, 0, 0, 16384);
		send_vertex(65536, 0, 0, 65536, 0, 0, 0, 16384);
		send_vertex(0, 65536, 0, 0, 65536, 0, 0, 16384);
		// zero determinant
		send_vertex(1, 2, 3, 7, 7, 16384, 0, 0);
		send_vertex(9, 8, 7, 7, 7, 0, 16384, 0);
		send_vertex(5, 1, 0, 7, 7, 0, 0, 16384);
		// normal parallel to the tangent
		send_vertex(0, 0, 0, 0, 0, 16384, 0, 0);
		send_vertex(100, 0, 0, 1, 0, 16384, 0, 0);
		send_vertex(0, 0, 0, 0, 1, -16384, 0, 0);
		// collinear edges: raw tangent zero
		send_vertex(4, 4, 4, 0, 0, 0, 16384, 0);
		send_vertex(4, 4, 4, 3, 0, 0, 16384, 0);
		send_vertex(4, 4, 4, 0, 3, 0, 16384, 0);
		// field extremes, negative determinant, normals out of range
		send_vertex(MN, MX, MN, MX, MN, -32768, 32767, 0);
		send_vertex(MX, MN, MX, MN, MN, 32767, -32768, -1);
		send_vertex(MN, MN, MX, MX, MX, 0, 0, 0);
		send_vertex(-1, -1, -1, -1, -1, -16384, -16384, -16384);
		send_vertex(MX, 0, MN, 0, MX, 16384, 16384, 16384);
		send_vertex(0, MX, -1, MN, 0, -1, 1, -1);
		push <= 1'b0;
		drain();
	endtask

	task automatic test_random();
		int idle_tx[3] = '{29, 77, 0};
		int idle_rx[3] = '{77, 29, 0};
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = idle_tx[ph];
			rx_idle = idle_rx[ph];
			repeat (28) send_random_triangle();
		end
		push <= 1'b0;
		drain();
	endtask

	task automatic test_backpressure();
		tx_idle = 0;
		rx_idle = 0;
		rx_hold = 5000;
		repeat (10) send_random_triangle();
		push <= 1'b0;
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		if (errors == 0)
			$display("triangle_tangent_generator_test: clean");
		else
			$display("triangle_tangent_generator_test: errors");
		$finish;
	end

endmodule
